/* sv/mte_pkg.sv */
package mte_pkg;

  localparam int HISTORY_FRAMES = 4096;
  localparam int ADDR_BITS      = $clog2(HISTORY_FRAMES);
  localparam int SAMPLE_BITS    = 16;
  localparam int FRAME_BITS     = 2 * SAMPLE_BITS;
  localparam int TAP_BITS       = 5;
  localparam int TERM_BITS      = SAMPLE_BITS + 1;
  localparam int ACC_BITS       = SAMPLE_BITS + 5;
  localparam int RECIP_SHIFT    = 20;
  localparam int RECIP_BITS     = 20;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_FRAMES   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXTRA_TAPS     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALTERNATE_SIGN = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINEAR_DIVISOR = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MULT,
    ST_ACC,
    ST_FINISH
  } mte_state_t;

  typedef struct packed {
    logic                load;
    logic [TAP_BITS-1:0] k;
    logic                linear;
    logic                negative;
    logic                entry_ok;
  } mte_tap_ctl_t;

  // ceil(2^20 / (k+1)); exact floor division for magnitudes up to 2^15
  function automatic logic [RECIP_BITS-1:0] recip(input logic [TAP_BITS-1:0] k);
    logic [RECIP_BITS-1:0] m;
    case (k)
      5'd1:    m = 20'd524288;
      5'd2:    m = 20'd349526;
      5'd3:    m = 20'd262144;
      5'd4:    m = 20'd209716;
      5'd5:    m = 20'd174763;
      5'd6:    m = 20'd149797;
      5'd7:    m = 20'd131072;
      5'd8:    m = 20'd116509;
      5'd9:    m = 20'd104858;
      5'd10:   m = 20'd95326;
      5'd11:   m = 20'd87382;
      5'd12:   m = 20'd80660;
      5'd13:   m = 20'd74899;
      5'd14:   m = 20'd69906;
      5'd15:   m = 20'd65536;
      5'd16:   m = 20'd61681;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* sv/mte_tap_div.sv */
module mte_tap_div (
  input  logic                                 clk,
  input  mte_pkg::mte_tap_ctl_t                ctl,
  input  logic signed [mte_pkg::SAMPLE_BITS-1:0] sample,
  output logic signed [mte_pkg::TERM_BITS-1:0]   term
);
  import mte_pkg::*;

  logic [SAMPLE_BITS-1:0]            mag;
  logic [SAMPLE_BITS+RECIP_BITS-1:0] prod;
  logic [SAMPLE_BITS-1:0]            pow_q;
  logic                              neg_r;
  logic                              lin_r;
  logic                              ok_r;
  logic [SAMPLE_BITS-1:0]            q;

  // magnitude of the most negative sample is still representable unsigned
  assign mag = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod  <= mag * recip(ctl.k);
      pow_q <= mag >> ctl.k;
      neg_r <= sample[SAMPLE_BITS-1] ^ ctl.negative;
      lin_r <= ctl.linear;
      ok_r  <= ctl.entry_ok;
    end
  end

  assign q = lin_r ? prod[RECIP_SHIFT +: SAMPLE_BITS] : pow_q;

  always_comb begin
    if (!ok_r) begin
      term = '0;
    end else if (neg_r) begin
      term = -$signed({1'b0, q});
    end else begin
      term = $signed({1'b0, q});
    end
  end

endmodule

/* sv/multi_tap_echo_mixer.sv */
// Stereo feedforward echo: each request is written to a 4096-frame history
// RAM, then taps 1 to extra_taps+1 are read back one at a time, at distance
// k*delay_frames, scaled and summed. Each tap runs the three-step read,
// multiply, accumulate sequence, as the history RAM has a single read port;
// the sum then goes to the output register. The next request is taken only
// after that, so a request is finished before the next one is accepted; the
// gap is longer while an earlier result still waits for out_ready.
// History slots not yet written since reset read as zero, tracked by the
// write pointer and a wrapped flag, so no clearing pass follows reset.
module multi_tap_echo_mixer (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [mte_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [mte_pkg::CFG_DATA_BITS-1:0]        cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [mte_pkg::SAMPLE_BITS-1:0]   left_in,
  input  logic signed [mte_pkg::SAMPLE_BITS-1:0]   right_in,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [mte_pkg::SAMPLE_BITS-1:0]   left_out,
  output logic signed [mte_pkg::SAMPLE_BITS-1:0]   right_out
);
  import mte_pkg::*;

  localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] SAT_LO = -SAT_HI - ACC_BITS'(1);

  logic [7:0] delay_frames;
  logic [3:0] extra_taps;
  logic       alternate_sign;
  logic       linear_divisor;

  mte_state_t state, state_next;

  logic [FRAME_BITS-1:0] history [HISTORY_FRAMES];
  logic [FRAME_BITS-1:0] rd_data;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [ADDR_BITS-1:0]  wp;
  logic                  wrapped;
  logic [ADDR_BITS-1:0]  tap_dist;
  logic [TAP_BITS-1:0]   k;
  logic [TAP_BITS-1:0]   last_k;
  logic                  entry_ok;

  logic signed [ACC_BITS-1:0] acc_l, acc_r;
  logic signed [ACC_BITS-1:0] half_l, half_r;
  logic signed [TERM_BITS-1:0] term_l, term_r;

  logic in_fire, rd_en, acc_en, fin_load, last_tap;
  mte_tap_ctl_t tap_ctl;

  assign in_fire  = in_valid && in_ready;
  assign last_k   = TAP_BITS'(extra_taps) + TAP_BITS'(1);
  assign last_tap = (k == last_k);
  assign rd_addr  = wp - tap_dist;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_frames   <= '0;
      extra_taps     <= '0;
      alternate_sign <= 1'b0;
      linear_divisor <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DELAY_FRAMES:   delay_frames   <= cfg_data;
        REG_EXTRA_TAPS:     extra_taps     <= cfg_data[3:0];
        REG_ALTERNATE_SIGN: alternate_sign <= cfg_data[0];
        REG_LINEAR_DIVISOR: linear_divisor <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_fire) state_next = ST_READ;
      ST_READ:   state_next = ST_MULT;
      ST_MULT:   state_next = ST_ACC;
      ST_ACC:    state_next = last_tap ? ST_FINISH : ST_READ;
      ST_FINISH: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    acc_en   = 1'b0;
    fin_load = 1'b0;
    tap_ctl  = '0;
    case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_READ:   rd_en = 1'b1;
      ST_MULT: begin
        tap_ctl.load     = 1'b1;
        tap_ctl.k        = k;
        tap_ctl.linear   = linear_divisor;
        tap_ctl.negative = alternate_sign && k[0];
        tap_ctl.entry_ok = entry_ok;
      end
      ST_ACC:    acc_en = 1'b1;
      ST_FINISH: fin_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // history RAM: write on acceptance, one registered read per tap
  always_ff @(posedge clk) begin
    if (in_fire) begin
      history[wp] <= {right_in, left_in};
    end
    if (rd_en) begin
      rd_data <= history[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (fin_load) begin
      wp <= wp + ADDR_BITS'(1);
      if (wp == ADDR_BITS'(HISTORY_FRAMES - 1)) begin
        wrapped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (in_fire) begin
      k <= TAP_BITS'(1);
    end else if (acc_en && !last_tap) begin
      k <= k + TAP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tap_dist <= ADDR_BITS'(delay_frames);
    end else if (acc_en) begin
      tap_dist <= tap_dist + ADDR_BITS'(delay_frames);
    end
    // slots ahead of the pointer are unwritten until the first wrap
    if (rd_en) begin
      entry_ok <= wrapped || (rd_addr <= wp);
    end
  end

  mte_tap_div u_div_l (
    .clk    (clk),
    .ctl    (tap_ctl),
    .sample ($signed(rd_data[SAMPLE_BITS-1:0])),
    .term   (term_l)
  );

  mte_tap_div u_div_r (
    .clk    (clk),
    .ctl    (tap_ctl),
    .sample ($signed(rd_data[FRAME_BITS-1:SAMPLE_BITS])),
    .term   (term_r)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_l <= ACC_BITS'(left_in);
      acc_r <= ACC_BITS'(right_in);
    end else if (acc_en) begin
      acc_l <= acc_l + ACC_BITS'(term_l);
      acc_r <= acc_r + ACC_BITS'(term_r);
    end
  end

  // halve toward zero
  assign half_l = $signed(acc_l + ACC_BITS'(acc_l[ACC_BITS-1])) >>> 1;
  assign half_r = $signed(acc_r + ACC_BITS'(acc_r[ACC_BITS-1])) >>> 1;

  always_ff @(posedge clk) begin
    if (fin_load) begin
      left_out  <= (half_l > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                   (half_l < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(half_l);
      right_out <= (half_r > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                   (half_r < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(half_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_read: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_READ)
    else $error("accepted request did not start a tap read");

  a_tap_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_MULT || state == ST_ACC) |->
      (k != '0 && k <= last_k))
    else $error("tap index outside configured range");

  a_pointer_advances: assert property (@(posedge clk) disable iff (rst)
    fin_load |=> wp == $past(wp) + ADDR_BITS'(1))
    else $error("write pointer did not advance with the result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !fin_load)
    else $error("waiting result overwritten");
`endif

endmodule

/* tb/echo_mix_checker.sv */
`timescale 1ns / 1ps

module echo_mix_checker
  import mte_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [SAMPLE_BITS-1:0] left_out,
  input  logic signed [SAMPLE_BITS-1:0] right_out,
  output int                            mismatches,
  output int                            pending,
  output int                            frames_checked
);

  localparam int SAMPLE_MAX = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int SAMPLE_MIN = -SAMPLE_MAX - 1;

  logic [FRAME_BITS-1:0] history [HISTORY_FRAMES];
  logic [ADDR_BITS-1:0]  write_pos;
  logic [7:0]            delay_frames;
  logic [3:0]            extra_taps;
  logic                  alternate_sign;
  logic                  linear_divisor;

  // {right, left} per outstanding request, oldest first
  logic [FRAME_BITS-1:0] mixes_due [$];

  // one channel of the echo sum; the current frame is already in the history
  function automatic logic [SAMPLE_BITS-1:0] mix_channel(input bit upper, input int dry);
    int                    acc;
    int                    tap;
    logic [ADDR_BITS-1:0]  slot;
    logic [FRAME_BITS-1:0] word;
    acc = dry;
    for (int k = 1; k <= int'(extra_taps) + 1; k++) begin
      slot = write_pos - ADDR_BITS'(k * int'(delay_frames));
      word = history[slot];
      tap = upper ? int'($signed(word[FRAME_BITS-1:SAMPLE_BITS]))
                  : int'($signed(word[SAMPLE_BITS-1:0]));
      if (alternate_sign && k[0]) tap = -tap;
      // SV division truncates toward zero, as required
      acc += tap / (linear_divisor ? k + 1 : 1 << k);
    end
    acc = acc / 2;
    if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
    if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
    return acc[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk) begin : track
    logic [FRAME_BITS-1:0] want;
    if (rst) begin
      for (int i = 0; i < HISTORY_FRAMES; i++) history[i] = '0;
      write_pos      = '0;
      delay_frames   = '0;
      extra_taps     = '0;
      alternate_sign = 1'b0;
      linear_divisor = 1'b0;
      mixes_due.delete();
      mismatches     = 0;
      frames_checked = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DELAY_FRAMES:   delay_frames   = cfg_data;
          REG_EXTRA_TAPS:     extra_taps     = cfg_data[3:0];
          REG_ALTERNATE_SIGN: alternate_sign = cfg_data[0];
          REG_LINEAR_DIVISOR: linear_divisor = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (mixes_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request outstanding, left %0d right %0d",
                   $time, left_out, right_out);
        end else begin
          want = mixes_due.pop_front();
          frames_checked++;
          if (left_out !== want[SAMPLE_BITS-1:0]) begin
            mismatches++;
            $display("%0t: left_out expected %0d actual %0d",
                     $time, $signed(want[SAMPLE_BITS-1:0]), left_out);
          end
          if (right_out !== want[FRAME_BITS-1:SAMPLE_BITS]) begin
            mismatches++;
            $display("%0t: right_out expected %0d actual %0d",
                     $time, $signed(want[FRAME_BITS-1:SAMPLE_BITS]), right_out);
          end
        end
      end
      if (in_valid && in_ready) begin
        history[write_pos] = {right_in, left_in};
        mixes_due.push_back({mix_channel(1'b1, right_in), mix_channel(1'b0, left_in)});
        write_pos = write_pos + ADDR_BITS'(1);
      end
    end
    pending <= mixes_due.size();
  end

endmodule

/* tb/multi_tap_echo_mixer_test.sv */
`timescale 1ns / 1ps

module multi_tap_echo_mixer_test;
  import mte_pkg::*;

  localparam int FRAMES_PER_SETTING = 50;
  localparam int RANDOM_SETTINGS    = 10;
  localparam int LONG_HOLD          = 400;
  localparam int SETTLE_CYCLES      = 60;
  localparam int CYCLE_LIMIT        = 400000;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] left_in   = '0;
  logic signed [SAMPLE_BITS-1:0] right_in  = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  int mismatches;
  int pending;
  int frames_checked;
  int tx_idle_pct   = 13;
  int rx_idle_pct   = 79;
  bit hold_request  = 1'b0;
  int cycles        = 0;
  int frames_sent   = 0;
  int settings_used = 1;

  multi_tap_echo_mixer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .left_in   (left_in),
    .right_in  (right_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out)
  );

  echo_mix_checker mix_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .left_in        (left_in),
    .right_in       (right_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .left_out       (left_out),
    .right_out      (right_out),
    .mismatches     (mismatches),
    .pending        (pending),
    .frames_checked (frames_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output side: random back-pressure, plus one long hold on request
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !held) begin
        held = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(19))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // valid is only dropped for an idle gap or a drain, so back-to-back requests keep it high
  task automatic send_frame(input logic [SAMPLE_BITS-1:0] left, input logic [SAMPLE_BITS-1:0] right);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    left_in  <= left;
    right_in <= right;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_echo(input logic [7:0] delay, input logic [7:0] taps,
                          input logic [7:0] alt, input logic [7:0] lin);
    cfg_write <= 1'b1;
    cfg_index <= REG_DELAY_FRAMES;
    cfg_data  <= delay;
    @(posedge clk);
    cfg_index <= REG_EXTRA_TAPS;
    cfg_data  <= taps;
    @(posedge clk);
    cfg_index <= REG_ALTERNATE_SIGN;
    cfg_data  <= alt;
    @(posedge clk);
    cfg_index <= REG_LINEAR_DIVISOR;
    cfg_data  <= lin;
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    logic [7:0] gap;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one tap at zero delay, so it echoes the current frame
    send_frame(16'h7FFF, 16'h7FFF);
    send_frame(16'h8000, 16'h8000);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h0000, 16'h0000);
    send_frame(16'hFFFF, 16'h0001);

    // sixteen alternating taps on the current frame; upper data bits dropped
    drain();
    set_echo(8'h00, 8'hFF, 8'h03, 8'h00);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h3039, 16'hFFFF);

    // linear divisor, all positive: sum overshoots and saturates
    drain();
    set_echo(8'h00, 8'h0F, 8'h00, 8'h01);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h4E20, 16'hB1E0);

    // deepest taps, 16 x 255 frames back
    drain();
    set_echo(8'hFF, 8'h0F, 8'h01, 8'hFF);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h0001, 16'hFFFF);
    send_frame(16'h5555, 16'hAAAA);

    drain();
    set_echo(8'h01, 8'hF0, 8'hFE, 8'h02);
    send_frame(16'h7FFF, 16'h7FFF);
    send_frame(16'h8000, 16'h8000);
    send_frame(16'h0000, 16'h0000);

    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      drain();
      if (p == 4) begin
        tx_idle_pct = 79;
        rx_idle_pct = 13;
      end
      if (p == 7) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(3))
        0:       gap = 8'($urandom_range(3));
        1, 2:    gap = 8'($urandom_range(4, 40));
        default: gap = 8'($urandom_range(255));
      endcase
      case (p)
        2:       set_echo(8'hFF, 8'($urandom) | 8'h0F, 8'($urandom), 8'($urandom));
        5:       set_echo(8'h00, 8'($urandom) & 8'hF0, 8'($urandom), 8'($urandom));
        default: set_echo(gap, 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      // sender keeps offering while the output is held, so the block backs up
      if (p == 7) hold_request = 1'b1;
      repeat (FRAMES_PER_SETTING) send_frame(pick_sample(), pick_sample());
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d of %0d stereo frames over %0d echo settings,",
             frames_checked, frames_sent, settings_used);
    $display("with saturation, zero and deepest delays and a %0d-cycle output hold.",
             LONG_HOLD);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
